/* design/nfsa_pkg.sv */
// Shared constants, codes and types of the next-fit slot allocator.
package nfsa_pkg;

	// Slot space
	localparam int NUM_CLASSES     = 5;
	localparam int MAX_SLOTS       = 4096;
	localparam int SLOT_W          = 12;
	localparam int COUNT_W         = 13;
	localparam int CLASS_W         = 3;

	// Occupancy memory: one 64-bit word covers 64 slots of one class
	localparam int WORD_W          = 64;
	localparam int BIT_W           = $clog2(WORD_W);
	localparam int SPAN_W          = BIT_W + 1;
	localparam int WORDS_PER_CLASS = MAX_SLOTS / WORD_W;
	localparam int WIDX_W          = SLOT_W - BIT_W;
	localparam int MEM_DEPTH       = NUM_CLASSES * WORDS_PER_CLASS;
	localparam int MEM_AW          = $clog2(MEM_DEPTH);

	// Configuration registers
	localparam int REG_IDX_W       = 3;
	localparam int NUM_COUNT_REGS  = 5;
	localparam logic [REG_IDX_W-1:0] REG_SCAN_LIMIT = 3'd5;
	localparam logic [COUNT_W-1:0] COUNT_RESET [NUM_COUNT_REGS] =
		'{13'd4096, 13'd4096, 13'd2560, 13'd2560, 13'd1280};
	localparam logic [COUNT_W-1:0] SCAN_LIMIT_RESET = 13'd300;

	// Request kinds
	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	// Response status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_BAD_SLOT  = 2'd3
	} status_t;

	// Outcome of one word scan
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
	} scan_res_t;

endpackage

/* design/nfsa_if.sv */
// Handshake channel interfaces: request, response and configuration write.
interface nfsa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [nfsa_pkg::CLASS_W-1:0] size_class;
	logic [nfsa_pkg::SLOT_W-1:0]  slot_in;

	modport source (output valid, mode, size_class, slot_in, input ready);
	modport sink (input valid, mode, size_class, slot_in, output ready);
endinterface

interface nfsa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [nfsa_pkg::SLOT_W-1:0] slot_out;

	modport source (output valid, status, slot_out, input ready);
	modport sink (input valid, status, slot_out, output ready);
endinterface

interface nfsa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nfsa_pkg::REG_IDX_W-1:0] index;
	logic [nfsa_pkg::COUNT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/next_fit_slot_allocator_unit.sv */
// Next-fit slot allocator: top level with occupancy memory, pointers and control.
//
// Channels: req (sink) carries mode, size_class and slot_in; rsp (source)
// returns status and slot_out, one transaction per request; cfg (sink) writes
// the five class counts (index 0..4) and the scan limit (index 5). cfg is
// always ready; the user must write it only while no request is in flight,
// which the block does not enforce. Occupancy is kept in a 320 x 64-bit
// synchronous memory, one word per 64 slots of a class. An allocate reads
// one word, masks it to the scan window and takes the lowest free bit; if
// none, it moves to the next word, wrapping at the class count, until the
// scan limit is used up. A bad free index, an empty class or a zero scan
// limit goes from request acceptance straight to the response register; a
// free reads and rewrites one word; an allocate visits at most ceil(L/64) + 2
// words, with L the scan limit capped at the class count (the class end can
// split a word). Each word takes a memory read state and an evaluate state;
// one request is in work at a time and the next is taken the cycle after the
// response register loads. The response register lets a new request be
// taken while the previous response waits; if the receiver stalls, the
// finished request waits and req.ready stays low until the response
// register frees up.
// Reset: counts and scan limit return to their defaults, pointers to zero,
// and a clearing pass over all 320 words zeroes the memory; req.ready stays
// low during the pass.
module next_fit_slot_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	nfsa_req_if.sink    req,
	nfsa_rsp_if.source  rsp,
	nfsa_cfg_if.sink    cfg
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [nfsa_pkg::COUNT_W-1:0] count_q [nfsa_pkg::NUM_COUNT_REGS];
	logic [nfsa_pkg::COUNT_W-1:0] scan_limit_q;

	// Next-fit pointers
	logic [nfsa_pkg::SLOT_W-1:0] ptr_q [nfsa_pkg::NUM_CLASSES];

	// Request context
	logic                          mode_q;
	logic [nfsa_pkg::CLASS_W-1:0]  cls_q;
	logic [nfsa_pkg::COUNT_W-1:0]  n_q;
	logic [nfsa_pkg::SLOT_W-1:0]   pos_q;
	logic [nfsa_pkg::COUNT_W-1:0]  rem_q;
	logic [1:0]                    res_status_q;
	logic [nfsa_pkg::SLOT_W-1:0]   res_slot_q;
	logic [nfsa_pkg::MEM_AW-1:0]   clr_idx_q;

	// Response register
	logic                          out_valid_q;
	logic [1:0]                    out_status_q;
	logic [nfsa_pkg::SLOT_W-1:0]   out_slot_q;

	// Occupancy memory
	logic [nfsa_pkg::WORD_W-1:0]   mem [nfsa_pkg::MEM_DEPTH];
	logic [nfsa_pkg::WORD_W-1:0]   rdata_q;
	logic                          mem_we;
	logic [nfsa_pkg::MEM_AW-1:0]   mem_waddr;
	logic [nfsa_pkg::WORD_W-1:0]   mem_wdata;
	logic [nfsa_pkg::MEM_AW-1:0]   cur_addr;

	// Accept-time decode
	logic                          req_fire;
	logic [nfsa_pkg::COUNT_W-1:0]  req_n;
	logic [nfsa_pkg::COUNT_W-1:0]  req_limit;
	logic [nfsa_pkg::SLOT_W-1:0]   req_ptr;
	logic [nfsa_pkg::SLOT_W-1:0]   req_start;

	// Evaluate-time datapath
	logic [nfsa_pkg::BIT_W-1:0]    off;
	logic [nfsa_pkg::COUNT_W-1:0]  to_end;
	logic [nfsa_pkg::COUNT_W-1:0]  span_w;
	logic [nfsa_pkg::SPAN_W-1:0]   span;
	logic [nfsa_pkg::COUNT_W-1:0]  pos_next;
	logic [nfsa_pkg::SLOT_W-1:0]   grant;
	logic [nfsa_pkg::COUNT_W-1:0]  grant_inc;
	logic [nfsa_pkg::WORD_W-1:0]   bit_sel;
	logic [nfsa_pkg::WORD_W-1:0]   hit_sel;
	logic                          out_free;
	nfsa_pkg::scan_res_t           scan;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.slot_out = out_slot_q;

	// Slot count of the requested class, saturated at the slot space
	always_comb begin
		req_n   = '0;
		req_ptr = '0;
		if (req.size_class < nfsa_pkg::CLASS_W'(nfsa_pkg::NUM_CLASSES)) begin
			req_ptr = ptr_q[req.size_class];
			if (count_q[req.size_class] > nfsa_pkg::COUNT_W'(nfsa_pkg::MAX_SLOTS)) begin
				req_n = nfsa_pkg::COUNT_W'(nfsa_pkg::MAX_SLOTS);
			end else begin
				req_n = count_q[req.size_class];
			end
		end
		req_limit = (scan_limit_q < req_n) ? scan_limit_q : req_n;
		// pointer left past a lowered count restarts at slot 0
		req_start = ({1'b0, req_ptr} >= req_n) ? '0 : req_ptr;
	end

	// Scan window of the current word: bounded by word end, budget and class end
	assign off     = pos_q[nfsa_pkg::BIT_W-1:0];
	assign to_end  = n_q - {1'b0, pos_q};
	assign cur_addr = nfsa_pkg::MEM_AW'({cls_q, pos_q[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W]});

	always_comb begin
		span_w = nfsa_pkg::COUNT_W'(nfsa_pkg::WORD_W) - nfsa_pkg::COUNT_W'(off);
		if (rem_q < span_w) begin
			span_w = rem_q;
		end
		if (to_end < span_w) begin
			span_w = to_end;
		end
	end

	assign span     = span_w[nfsa_pkg::SPAN_W-1:0];
	assign pos_next = {1'b0, pos_q} + span_w;

	nfsa_word_scan u_scan (
		.word (rdata_q),
		.off  (off),
		.span (span),
		.res  (scan)
	);

	assign grant     = {pos_q[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W], scan.bit_idx};
	assign grant_inc = {1'b0, grant} + 1'b1;
	assign bit_sel   = nfsa_pkg::WORD_W'(1) << off;
	assign hit_sel   = nfsa_pkg::WORD_W'(1) << scan.bit_idx;

	// Memory write port: clearing pass, free, or grant
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = rdata_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
			end
			ST_EVAL: begin
				if (mode_q == nfsa_pkg::MODE_FREE) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q & ~bit_sel;
				end else if (scan.found) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q | hit_sel;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Occupancy memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem[cur_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= nfsa_pkg::COUNT_RESET;
			scan_limit_q <= nfsa_pkg::SCAN_LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index < nfsa_pkg::REG_IDX_W'(nfsa_pkg::NUM_COUNT_REGS)) begin
				count_q[cfg.index] <= cfg.data;
			end else if (cfg.index == nfsa_pkg::REG_SCAN_LIMIT) begin
				scan_limit_q <= cfg.data;
			end
		end
	end

	// Control sequencer, pointers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			ptr_q        <= '{default: '0};
			mode_q       <= 1'b0;
			cls_q        <= '0;
			n_q          <= '0;
			pos_q        <= '0;
			rem_q        <= '0;
			res_status_q <= '0;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_slot_q   <= '0;
		end else begin
			// in ST_DONE a taken response is replaced by the next one below
			if (rsp.valid && rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == nfsa_pkg::MEM_AW'(nfsa_pkg::MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						mode_q     <= req.mode;
						cls_q      <= req.size_class;
						n_q        <= req_n;
						rem_q      <= req_limit;
						res_slot_q <= '0;
						if (req.mode == nfsa_pkg::MODE_FREE) begin
							pos_q <= req.slot_in;
							if ({1'b0, req.slot_in} >= req_n) begin
								res_status_q <= nfsa_pkg::STAT_BAD_SLOT;
								state_q      <= ST_DONE;
							end else begin
								res_status_q <= nfsa_pkg::STAT_OK;
								state_q      <= ST_READ;
							end
						end else begin
							pos_q <= req_start;
							if (req_n == '0) begin
								res_status_q <= nfsa_pkg::STAT_EMPTY;
								state_q      <= ST_DONE;
							end else if (req_limit == '0) begin
								res_status_q <= nfsa_pkg::STAT_EXHAUSTED;
								state_q      <= ST_DONE;
							end else begin
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (mode_q == nfsa_pkg::MODE_FREE) begin
						res_status_q <= nfsa_pkg::STAT_OK;
						state_q      <= ST_DONE;
					end else if (scan.found) begin
						res_status_q <= nfsa_pkg::STAT_OK;
						res_slot_q   <= grant;
						ptr_q[cls_q] <= (grant_inc == n_q) ? '0 :
							grant_inc[nfsa_pkg::SLOT_W-1:0];
						state_q      <= ST_DONE;
					end else if (rem_q == span_w) begin
						// budget used up without a free slot
						res_status_q <= nfsa_pkg::STAT_EXHAUSTED;
						state_q      <= ST_DONE;
					end else begin
						rem_q   <= rem_q - span_w;
						pos_q   <= (pos_next == n_q) ? '0 :
							pos_next[nfsa_pkg::SLOT_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// A granted slot always lies inside its class
	a_grant_in_class: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && mode_q == nfsa_pkg::MODE_ALLOC && scan.found)
			|-> ({1'b0, grant} < n_q))
		else $error("granted slot beyond class count");

	// Scan position and remaining budget stay within the class
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && mode_q == nfsa_pkg::MODE_ALLOC)
			|-> ({1'b0, pos_q} < n_q && rem_q != '0 && rem_q <= n_q))
		else $error("scan state out of bounds");

	// Only a successful request carries a nonzero slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != nfsa_pkg::STAT_OK) |-> (out_slot_q == '0))
		else $error("failed request returned a slot");
`endif

endmodule

/* design/nfsa_word_scan.sv */
// Finds the lowest free slot of one occupancy word inside a window of bits.
module nfsa_word_scan (
	input  logic [nfsa_pkg::WORD_W-1:0] word,
	input  logic [nfsa_pkg::BIT_W-1:0]  off,
	input  logic [nfsa_pkg::SPAN_W-1:0] span,
	output nfsa_pkg::scan_res_t         res
);

	logic [nfsa_pkg::WORD_W-1:0] window;
	logic [nfsa_pkg::WORD_W-1:0] cand;
	logic [nfsa_pkg::SPAN_W-1:0] stop;

	// Window covers bits off .. off+span-1 (never past the word end)
	assign stop = {1'b0, off} + span;

	always_comb begin
		for (int b = 0; b < nfsa_pkg::WORD_W; b++) begin
			window[b] = (nfsa_pkg::SPAN_W'(b) >= {1'b0, off}) &&
				(nfsa_pkg::SPAN_W'(b) < stop);
		end
	end

	assign cand = ~word & window;

	// Priority encoder, lowest free bit wins
	always_comb begin
		res = '0;
		for (int b = nfsa_pkg::WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				res.found   = 1'b1;
				res.bit_idx = nfsa_pkg::BIT_W'(b);
			end
		end
	end

endmodule

/* verif/next_fit_slot_allocator_unit_tb.sv */
// Testbench for the next-fit slot allocator: directed and random requests vs. a predictor.
`timescale 1ns / 100ps

module next_fit_slot_allocator_unit_tb;

	typedef logic [nfsa_pkg::REG_IDX_W-1:0] reg_idx_t;

	typedef struct {
		nfsa_pkg::mode_t              mode;
		logic [nfsa_pkg::CLASS_W-1:0] cls;
		logic [nfsa_pkg::SLOT_W-1:0]  slot;
	} request_t;

	typedef struct {
		nfsa_pkg::status_t           status;
		logic [nfsa_pkg::SLOT_W-1:0] slot;
	} reply_t;

	localparam reg_idx_t REG_COUNT_BASE = 3'd0;
	localparam int       STALL_LIMIT    = 3000;
	localparam int       HOLD_CYCLES    = 150;
	localparam int       PHASE_ITEMS    = 80;
	localparam int       RANDOM_PHASES  = 9;
	localparam int       MAX_REPORTS    = 40;

	logic clk;
	logic arst_n;

	nfsa_req_if req_ch ();
	nfsa_rsp_if rsp_ch ();
	nfsa_cfg_if cfg_ch ();

	next_fit_slot_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: occupancy, next-fit pointers and register copies
	bit               occ_map [nfsa_pkg::NUM_CLASSES][nfsa_pkg::MAX_SLOTS];
	int               next_ptr [nfsa_pkg::NUM_CLASSES];
	logic [nfsa_pkg::COUNT_W-1:0] count_reg [nfsa_pkg::NUM_COUNT_REGS];
	int               scan_reg;

	// Counts as planned by the stimulus, used only to aim slot indexes
	logic [nfsa_pkg::COUNT_W-1:0] planned_count [nfsa_pkg::NUM_COUNT_REGS];

	request_t pending_requests [$];
	reply_t   expected_replies [$];
	request_t next_item;

	bit req_taken;
	bit press_go;
	int burst_left;
	int gap_left;
	int hold_left;
	int rx_mode;
	int rx_left;
	int idle_cycles;
	int errors;
	int reports;
	int status_seen [4];
	int config_sets;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int slot_span(logic [nfsa_pkg::COUNT_W-1:0] v);
		return (v > nfsa_pkg::MAX_SLOTS) ? nfsa_pkg::MAX_SLOTS : int'(v);
	endfunction

	function automatic int class_slots(int c);
		return (c >= nfsa_pkg::NUM_CLASSES) ? 0 : slot_span(count_reg[c]);
	endfunction

	function automatic int planned_slots(int c);
		return (c >= nfsa_pkg::NUM_CLASSES) ? 0 : slot_span(planned_count[c]);
	endfunction

	function automatic void reset_model();
		for (int c = 0; c < nfsa_pkg::NUM_CLASSES; c++) begin
			next_ptr[c] = 0;
			for (int s = 0; s < nfsa_pkg::MAX_SLOTS; s++)
				occ_map[c][s] = 1'b0;
		end
		for (int k = 0; k < nfsa_pkg::NUM_COUNT_REGS; k++) begin
			count_reg[k] = nfsa_pkg::COUNT_RESET[k];
			planned_count[k] = nfsa_pkg::COUNT_RESET[k];
		end
		scan_reg = nfsa_pkg::SCAN_LIMIT_RESET;
	endfunction

	// Next-fit allocate / free, updates occupancy and pointer
	function automatic reply_t compute_reply(request_t r);
		reply_t rep;
		int     n;
		int     lim;
		int     idx;
		bit     hit;
		rep.status = nfsa_pkg::STAT_OK;
		rep.slot = '0;
		n = class_slots(r.cls);
		if (r.mode == nfsa_pkg::MODE_FREE) begin
			if (int'(r.slot) >= n)
				rep.status = nfsa_pkg::STAT_BAD_SLOT;
			else
				occ_map[r.cls][r.slot] = 1'b0;
		end else if (n == 0) begin
			rep.status = nfsa_pkg::STAT_EMPTY;
		end else begin
			lim = (scan_reg < n) ? scan_reg : n;
			idx = (next_ptr[r.cls] >= n) ? 0 : next_ptr[r.cls];
			hit = 1'b0;
			for (int i = 0; i < lim && !hit; i++) begin
				if (!occ_map[r.cls][idx]) begin
					occ_map[r.cls][idx] = 1'b1;
					rep.slot = nfsa_pkg::SLOT_W'(idx);
					next_ptr[r.cls] = (idx + 1) % n;
					hit = 1'b1;
				end else begin
					idx = (idx + 1) % n;
				end
			end
			if (!hit)
				rep.status = nfsa_pkg::STAT_EXHAUSTED;
		end
		return rep;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		errors++;
		reports++;
		if (reports <= MAX_REPORTS)
			$display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
	endtask

	task automatic push_req(input nfsa_pkg::mode_t mode, input int cls, input int slot);
		request_t r;
		r.mode = mode;
		r.cls = nfsa_pkg::CLASS_W'(cls);
		r.slot = nfsa_pkg::SLOT_W'(slot);
		pending_requests.push_back(r);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [nfsa_pkg::COUNT_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		if (idx < nfsa_pkg::NUM_COUNT_REGS)
			planned_count[idx] = val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic cfg_release();
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		config_sets++;
		@(posedge clk);
	endtask

	// Block idle: nothing queued, offered or outstanding
	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_replies.size() != 0 || req_ch.valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [nfsa_pkg::COUNT_W-1:0] pick_count();
		case ($urandom_range(9))
			0: return '0;
			1: return nfsa_pkg::COUNT_W'($urandom_range(8191, 4096));
			2: return nfsa_pkg::COUNT_W'($urandom_range(4096));
			default: return nfsa_pkg::COUNT_W'($urandom_range(150, 1));
		endcase
	endfunction

	function automatic logic [nfsa_pkg::COUNT_W-1:0] pick_scan();
		case ($urandom_range(9))
			0: return '0;
			1, 2: return nfsa_pkg::COUNT_W'($urandom_range(8191, 4096));
			3, 4: return nfsa_pkg::COUNT_W'($urandom_range(300, 1));
			default: return nfsa_pkg::COUNT_W'($urandom_range(24, 1));
		endcase
	endfunction

	// New settings, then a batch of mixed allocate/free requests
	task automatic random_phase(input int items);
		int cls;
		int n;
		int slot;
		for (int k = 0; k < nfsa_pkg::NUM_COUNT_REGS; k++)
			cfg_write(reg_idx_t'(REG_COUNT_BASE + k), pick_count());
		cfg_write(nfsa_pkg::REG_SCAN_LIMIT, pick_scan());
		cfg_release();
		for (int k = 0; k < items; k++) begin
			cls = ($urandom_range(9) == 0) ? $urandom_range(7, nfsa_pkg::NUM_CLASSES) :
				$urandom_range(nfsa_pkg::NUM_CLASSES - 1);
			n = planned_slots(cls);
			if ($urandom_range(99) < 55) begin
				push_req(nfsa_pkg::MODE_ALLOC, cls, $urandom_range(nfsa_pkg::MAX_SLOTS - 1));
			end else begin
				case ($urandom_range(9))
					0: slot = $urandom_range(nfsa_pkg::MAX_SLOTS - 1);
					1: slot = (n < nfsa_pkg::MAX_SLOTS) ? n : nfsa_pkg::MAX_SLOTS - 1;
					2: slot = (n > 0) ? n - 1 : 0;
					default: slot = (n > 0) ? $urandom_range(n - 1) :
						$urandom_range(nfsa_pkg::MAX_SLOTS - 1);
				endcase
				push_req(nfsa_pkg::MODE_FREE, cls, slot);
			end
		end
	endtask

	// Predictor: track register writes and accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index < nfsa_pkg::NUM_COUNT_REGS)
					count_reg[cfg_ch.index] = cfg_ch.data;
				else if (cfg_ch.index == nfsa_pkg::REG_SCAN_LIMIT)
					scan_reg = cfg_ch.data;
			end
			if (req_ch.valid && req_ch.ready) begin
				expected_replies.push_back(compute_reply(request_t'{
					nfsa_pkg::mode_t'(req_ch.mode), req_ch.size_class, req_ch.slot_in}));
				req_taken = 1'b1;
			end
		end
	end

	// Request driver: bursts with random gaps, holds each offer until it is accepted
	always @(negedge clk) begin
		if (req_ch.valid && !req_taken) begin
			// offer stays up
		end else if (gap_left > 0) begin
			gap_left--;
			req_ch.valid <= 1'b0;
		end else if (pending_requests.size() != 0) begin
			next_item = pending_requests.pop_front();
			req_ch.mode <= next_item.mode;
			req_ch.size_class <= next_item.cls;
			req_ch.slot_in <= next_item.slot;
			req_ch.valid <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(24, 1);
				gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			end
		end else begin
			req_ch.valid <= 1'b0;
		end
		req_taken = 1'b0;
	end

	// Response receiver: stall pattern switches among modes, plus one long hold
	always @(negedge clk) begin
		logic rdy;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (press_go) begin
			press_go = 1'b0;
			hold_left = HOLD_CYCLES;
			rdy = 1'b0;
		end else begin
			if (rx_left <= 0) begin
				rx_mode = $urandom_range(2);
				rx_left = $urandom_range(60, 5);
			end
			rx_left--;
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(1));
				default: rdy = ($urandom_range(3) == 0);
			endcase
		end
		rsp_ch.ready <= rdy;
	end

	// Response monitor: compare each transaction with the oldest expectation
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected response, status", rsp_ch.status, -1);
			end else begin
				want = expected_replies.pop_front();
				status_seen[want.status]++;
				if (rsp_ch.status !== want.status)
					report_mismatch("status", rsp_ch.status, want.status);
				if (rsp_ch.slot_out !== want.slot)
					report_mismatch("slot_out", rsp_ch.slot_out, want.slot);
			end
		end
	end

	// Watchdog: any channel moving resets the count
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d idle cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = nfsa_pkg::MODE_ALLOC;
		req_ch.size_class = '0;
		req_ch.slot_in = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		burst_left = 1;
		gap_left = 0;
		hold_left = 0;
		rx_left = 0;
		press_go = 1'b0;
		req_taken = 1'b0;
		idle_cycles = 0;
		errors = 0;
		reports = 0;
		config_sets = 0;
		for (int k = 0; k < 4; k++)
			status_seen[k] = 0;
		reset_model();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Default counts: first grants, empty classes, bad and repeated frees
		push_req(nfsa_pkg::MODE_ALLOC, 0, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 1, nfsa_pkg::MAX_SLOTS - 1);
		push_req(nfsa_pkg::MODE_ALLOC, 2, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 3, $urandom_range(nfsa_pkg::MAX_SLOTS - 1));
		push_req(nfsa_pkg::MODE_ALLOC, 4, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 5, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 7, nfsa_pkg::MAX_SLOTS - 1);
		push_req(nfsa_pkg::MODE_FREE, 6, 0);
		push_req(nfsa_pkg::MODE_FREE, 0, nfsa_pkg::MAX_SLOTS - 1);
		push_req(nfsa_pkg::MODE_FREE, 4, 1280);
		push_req(nfsa_pkg::MODE_FREE, 4, 1279);
		push_req(nfsa_pkg::MODE_FREE, 0, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 0, 0);
		push_req(nfsa_pkg::MODE_FREE, 2, 2560);
		wait_drained();

		// Tiny and saturated counts, pointer past a lowered count, one-slot scan
		cfg_write(REG_COUNT_BASE + 3'd0, 13'd1);
		cfg_write(REG_COUNT_BASE + 3'd1, 13'd0);
		cfg_write(REG_COUNT_BASE + 3'd2, 13'd8191);
		cfg_write(REG_COUNT_BASE + 3'd3, 13'd4096);
		cfg_write(REG_COUNT_BASE + 3'd4, 13'd3);
		cfg_write(nfsa_pkg::REG_SCAN_LIMIT, 13'd1);
		cfg_release();
		push_req(nfsa_pkg::MODE_ALLOC, 0, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 0, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 1, 0);
		push_req(nfsa_pkg::MODE_FREE, 1, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 4, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 4, 0);
		push_req(nfsa_pkg::MODE_ALLOC, 4, 0);
		push_req(nfsa_pkg::MODE_FREE, 2, nfsa_pkg::MAX_SLOTS - 1);
		wait_drained();

		// Zero scan limit examines nothing
		cfg_write(nfsa_pkg::REG_SCAN_LIMIT, 13'd0);
		cfg_release();
		push_req(nfsa_pkg::MODE_ALLOC, 3, 0);
		wait_drained();

		// Scan limit far above the count wraps the whole class once
		cfg_write(nfsa_pkg::REG_SCAN_LIMIT, 13'd8191);
		cfg_release();
		push_req(nfsa_pkg::MODE_ALLOC, 4, 0);
		push_req(nfsa_pkg::MODE_FREE, 4, 1);
		push_req(nfsa_pkg::MODE_ALLOC, 4, 0);
		wait_drained();

		// Random settings; one phase holds the response side off to back up requests
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_phase(PHASE_ITEMS);
			if (p == 3)
				press_go = 1'b1;
			wait_drained();
		end

		wait_drained();
		repeat (16) @(posedge clk);
		$display("Ran %0d register settings; responses: %0d ok, %0d exhausted, %0d empty class,",
			config_sets, status_seen[nfsa_pkg::STAT_OK], status_seen[nfsa_pkg::STAT_EXHAUSTED],
			status_seen[nfsa_pkg::STAT_EMPTY]);
		$display("%0d bad slot index; %0d mismatches", status_seen[nfsa_pkg::STAT_BAD_SLOT],
			errors);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
